/* src/assert_macros.svh */
// assertion macros shared by the rtl files
// each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AST_IMP(lbl, ante, cons)
`define AST_NXT(lbl, ante, cons)
`endif
`endif

/* src/alfp_pkg.sv */
package alfp_pkg;

	// pool geometry
	localparam int NODES       = 64;
	localparam int RECORD_BITS = 32;
	localparam int AW          = $clog2(NODES);
	localparam int IDX_W       = $clog2(NODES + 1);
	localparam int CAP_W       = 7;
	localparam int CMP_W       = (CAP_W > IDX_W) ? CAP_W : IDX_W;

	localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(NODES);

	// request kinds
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_DEAD = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic take;
		logic cfg_wr;
		logic app_issue;
		logic app_done;
		logic look_issue;
		logic look_done;
		logic rm_link;
		logic rm_done;
		logic fail_full;
		logic fail_dead;
		logic idle_res;
		logic load_out;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       live;
		logic       free_none;
	} dp_stat_t;

	// one result beat
	typedef struct packed {
		logic [1:0]             status;
		logic [IDX_W-1:0]       node_index;
		logic [RECORD_BITS-1:0] record;
		logic [IDX_W-1:0]       next_node;
		logic [IDX_W-1:0]       prev_node;
		logic [IDX_W-1:0]       head_node;
		logic [IDX_W-1:0]       tail_node;
		logic [IDX_W-1:0]       count;
		logic                   full_res;
	} res_t;

endpackage

/* src/alfp_if.sv */
// request channel
interface alfp_in_if import alfp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             kind;
	logic [AW-1:0]          node;
	logic [RECORD_BITS-1:0] value;

	modport source (output valid, kind, node, value, input ready);
	modport sink (input valid, kind, node, value, output ready);
endinterface

// result channel
interface alfp_out_if import alfp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [IDX_W-1:0]       node_index;
	logic [RECORD_BITS-1:0] record;
	logic [IDX_W-1:0]       next_node;
	logic [IDX_W-1:0]       prev_node;
	logic [IDX_W-1:0]       head_node;
	logic [IDX_W-1:0]       tail_node;
	logic [IDX_W-1:0]       count;
	logic                   full_res;

	modport source (output valid, status, node_index, record, next_node, prev_node,
		head_node, tail_node, count, full_res, input ready);
	modport sink (input valid, status, node_index, record, next_node, prev_node,
		head_node, tail_node, count, full_res, output ready);
endinterface

// capacity write channel
interface alfp_cfg_if import alfp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

/* src/alfp_ram.sv */
module alfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/alfp_ctrl.sv */
`include "assert_macros.svh"

module alfp_ctrl import alfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     res_ready,
	output logic     res_valid,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_APP  = 3'd2;
	localparam logic [2:0] S_LOOK = 3'd3;
	localparam logic [2:0] S_RM   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// sequencing of one operation
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		cfg_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cfg_ready  = 1'b1;
				item_ready = !cfg_valid;
				cmd.cfg_wr = cfg_valid;
				if (item_valid && !cfg_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.kind)
					KIND_APPEND: begin
						if (stat.free_none) begin
							cmd.fail_full = 1'b1;
							state_d       = S_DONE;
						end else begin
							cmd.app_issue = 1'b1;
							state_d       = S_APP;
						end
					end
					KIND_REMOVE, KIND_READ: begin
						if (!stat.live) begin
							cmd.fail_dead = 1'b1;
							state_d       = S_DONE;
						end else begin
							cmd.look_issue = 1'b1;
							state_d        = S_LOOK;
						end
					end
					default: begin
						cmd.idle_res = 1'b1;
						state_d      = S_DONE;
					end
				endcase
			end
			S_APP: begin
				cmd.app_done = 1'b1;
				state_d      = S_DONE;
			end
			S_LOOK: begin
				if (stat.kind == KIND_REMOVE) begin
					cmd.rm_link = 1'b1;
					state_d     = S_RM;
				end else begin
					cmd.look_done = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_RM: begin
				cmd.rm_done = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || res_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

	`AST_IMP(a_accept_idle, item_valid && item_ready, state_q == S_IDLE)
	`AST_NXT(a_load_valid, cmd.load_out, out_valid_q)
	`AST_IMP(a_stall_hold, state_q == S_DONE && out_valid_q && !res_ready, !cmd.load_out)

endmodule

/* src/alfp_dp.sv */
`include "assert_macros.svh"

module alfp_dp import alfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  logic [1:0]             kind,
	input  logic [AW-1:0]          node,
	input  logic [RECORD_BITS-1:0] value,
	input  logic [CAP_W-1:0]       capacity,
	output res_t                   out_q
);

	// list control state
	logic [IDX_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [IDX_W-1:0] free_q;
	logic [IDX_W-1:0] count_q;
	logic [NODES-1:0] live_q;
	logic [NODES-1:0] nv_q;
	logic [NODES-1:0] pv_q;

	// held request
	logic [1:0]             kind_q;
	logic [AW-1:0]          node_q;
	logic [RECORD_BITS-1:0] value_q;
	logic [IDX_W-1:0]       node_x;

	// read side
	logic             nv_rd_q;
	logic             pv_rd_q;
	logic [AW-1:0]    rd_addr_q;
	logic [IDX_W-1:0] nxt_ram_q;
	logic [IDX_W-1:0] prv_ram_q;
	logic [IDX_W-1:0] nxt_rd;
	logic [IDX_W-1:0] prv_rd;
	logic [IDX_W-1:0] dflt_next;
	logic [RECORD_BITS-1:0] rec_rd;

	// memory ports
	logic                   nxt_we;
	logic [AW-1:0]          nxt_wa;
	logic [IDX_W-1:0]       nxt_wd;
	logic                   prv_we;
	logic [AW-1:0]          prv_wa;
	logic [IDX_W-1:0]       prv_wd;
	logic                   rd_re;
	logic [AW-1:0]          rd_ra;

	// capacity write values
	logic [IDX_W-1:0] cap_new;

	// result
	res_t res_q;
	res_t res_d;
	logic res_we;

	assign node_x = IDX_W'(node_q);

	assign cap_new = (CMP_W'(capacity) > CMP_W'(NODES)) ? NONE_IDX : IDX_W'(capacity);

	// status for the controller
	assign stat.kind      = kind_q;
	assign stat.live      = live_q[node_q];
	assign stat.free_none = (free_q == NONE_IDX);

	// links not yet written read as the fresh free chain
	assign dflt_next = ((IDX_W'(rd_addr_q) + IDX_W'(1)) < cap_q) ?
		(IDX_W'(rd_addr_q) + IDX_W'(1)) : NONE_IDX;
	assign nxt_rd    = nv_rd_q ? nxt_ram_q : dflt_next;
	assign prv_rd    = pv_rd_q ? prv_ram_q : NONE_IDX;

	// read address, shared by the three memories
	assign rd_re = cmd.app_issue || cmd.look_issue;
	assign rd_ra = cmd.app_issue ? free_q[AW-1:0] : node_q;

	// next link write port
	always_comb begin
		nxt_we = 1'b0;
		nxt_wa = free_q[AW-1:0];
		nxt_wd = NONE_IDX;
		if (cmd.app_issue && tail_q != NONE_IDX) begin
			nxt_we = 1'b1;
			nxt_wa = tail_q[AW-1:0];
			nxt_wd = free_q;
		end
		if (cmd.app_done) begin
			nxt_we = 1'b1;
			nxt_wa = free_q[AW-1:0];
			nxt_wd = NONE_IDX;
		end
		if (cmd.rm_link && prv_rd != NONE_IDX) begin
			nxt_we = 1'b1;
			nxt_wa = prv_rd[AW-1:0];
			nxt_wd = nxt_rd;
		end
		if (cmd.rm_done) begin
			nxt_we = 1'b1;
			nxt_wa = node_q;
			nxt_wd = free_q;
		end
	end

	// prev link write port
	always_comb begin
		prv_we = 1'b0;
		prv_wa = free_q[AW-1:0];
		prv_wd = NONE_IDX;
		if (cmd.app_issue) begin
			prv_we = 1'b1;
			prv_wa = free_q[AW-1:0];
			prv_wd = tail_q;
		end
		if (cmd.rm_link && nxt_rd != NONE_IDX) begin
			prv_we = 1'b1;
			prv_wa = nxt_rd[AW-1:0];
			prv_wd = prv_rd;
		end
		if (cmd.rm_done) begin
			prv_we = 1'b1;
			prv_wa = node_q;
			prv_wd = NONE_IDX;
		end
	end

	alfp_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_wa),
		.wdata (nxt_wd),
		.re    (rd_re),
		.raddr (rd_ra),
		.rdata (nxt_ram_q)
	);

	alfp_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prv_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_wa),
		.wdata (prv_wd),
		.re    (rd_re),
		.raddr (rd_ra),
		.rdata (prv_ram_q)
	);

	alfp_ram #(.WIDTH(RECORD_BITS), .DEPTH(NODES)) u_rec_ram (
		.clk   (clk),
		.we    (cmd.app_issue),
		.waddr (free_q[AW-1:0]),
		.wdata (value_q),
		.re    (rd_re),
		.raddr (rd_ra),
		.rdata (rec_rd)
	);

	// result of the current operation
	always_comb begin
		res_d.status     = STAT_OK;
		res_d.node_index = NONE_IDX;
		res_d.record     = '0;
		res_d.next_node  = NONE_IDX;
		res_d.prev_node  = NONE_IDX;
		res_d.head_node  = head_q;
		res_d.tail_node  = tail_q;
		res_d.count      = count_q;
		res_d.full_res   = (free_q == NONE_IDX) && (cap_q != '0);
		if (cmd.fail_full) begin
			res_d.status = STAT_FULL;
		end
		if (cmd.fail_dead) begin
			res_d.status = STAT_DEAD;
		end
		if (cmd.app_done) begin
			res_d.node_index = free_q;
			res_d.record     = value_q;
			res_d.prev_node  = tail_q;
			res_d.head_node  = (tail_q == NONE_IDX) ? free_q : head_q;
			res_d.tail_node  = free_q;
			res_d.count      = count_q + IDX_W'(1);
			res_d.full_res   = (nxt_rd == NONE_IDX) && (cap_q != '0);
		end
		if (cmd.look_done || cmd.rm_link) begin
			res_d.node_index = node_x;
			res_d.record     = rec_rd;
			res_d.next_node  = nxt_rd;
			res_d.prev_node  = prv_rd;
		end
		if (cmd.rm_link) begin
			res_d.head_node = (head_q == node_x) ? nxt_rd : head_q;
			res_d.tail_node = (tail_q == node_x) ? prv_rd : tail_q;
			res_d.count     = count_q - IDX_W'(1);
			res_d.full_res  = 1'b0;
		end
	end

	assign res_we = cmd.fail_full || cmd.fail_dead || cmd.idle_res ||
		cmd.app_done || cmd.look_done || cmd.rm_link;

	// list pointers, live marks and link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= NONE_IDX;
			head_q  <= NONE_IDX;
			tail_q  <= NONE_IDX;
			free_q  <= '0;
			count_q <= '0;
			live_q  <= '0;
			nv_q    <= '0;
			pv_q    <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q   <= cap_new;
			head_q  <= NONE_IDX;
			tail_q  <= NONE_IDX;
			free_q  <= (cap_new != '0) ? '0 : NONE_IDX;
			count_q <= '0;
			live_q  <= '0;
			nv_q    <= '0;
			pv_q    <= '0;
		end else begin
			if (nxt_we) begin
				nv_q[nxt_wa] <= 1'b1;
			end
			if (prv_we) begin
				pv_q[prv_wa] <= 1'b1;
			end
			if (cmd.app_issue) begin
				live_q[free_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.app_done) begin
				free_q  <= nxt_rd;
				tail_q  <= free_q;
				count_q <= count_q + IDX_W'(1);
				if (tail_q == NONE_IDX) begin
					head_q <= free_q;
				end
			end
			if (cmd.rm_link) begin
				live_q[node_q] <= 1'b0;
				count_q        <= count_q - IDX_W'(1);
				if (head_q == node_x) begin
					head_q <= nxt_rd;
				end
				if (tail_q == node_x) begin
					tail_q <= prv_rd;
				end
			end
			if (cmd.rm_done) begin
				free_q <= node_x;
			end
		end
	end

	// request, read side and result registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q  <= kind;
			node_q  <= node;
			value_q <= value;
		end
		if (rd_re) begin
			nv_rd_q   <= nv_q[rd_ra];
			pv_rd_q   <= pv_q[rd_ra];
			rd_addr_q <= rd_ra;
		end
		if (res_we) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	// the free head of a remove lands in the cycle after the count drops
	`AST_IMP(a_cnt_cap, 1'b1, count_q <= cap_q)
	`AST_IMP(a_ends_pair, 1'b1, (head_q == NONE_IDX) == (tail_q == NONE_IDX))
	`AST_IMP(a_empty_cnt, 1'b1, (head_q == NONE_IDX) == (count_q == '0))
	`AST_IMP(a_free_none, free_q == NONE_IDX && !cmd.rm_done, count_q == cap_q)

endmodule

/* src/array_linked_list_free_pool_top.sv */
// Pool of record nodes kept as a doubly linked list with a free chain.
// Channels: item (kind, node, value) in, result out, cfg writes capacity;
// each moves a beat when valid and ready are both high.
// append takes the free head and links it after the tail, remove unlinks a
// live node and pushes it on the free head, read returns a node's record
// and neighbours; every result carries head, tail, count and the full flag.
// One item at a time; an item is taken only while the sequencer is idle.
// Append issues then completes; read looks up then completes; remove looks
// up, unlinks, then pushes the freed node; a rejected or unused kind goes
// straight to the result. These steps follow from the registered read of
// the link memories and the single write port of each: remove needs two write slots.
// Reset and capacity writes empty the list and restore the free chain in
// index order at once, through per-entry valid bits on the link memories;
// there is no clearing pass. Capacity is taken only while idle.
// A stalled receiver holds the result register; the sequencer waits with
// the next finished result and takes no new item until it moves.
module array_linked_list_free_pool_top import alfp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	alfp_in_if.sink  item,
	alfp_out_if.source result,
	alfp_cfg_if.sink cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     res;

	alfp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.cfg_valid  (cfg.valid),
		.cfg_ready  (cfg.ready),
		.res_ready  (result.ready),
		.res_valid  (result.valid),
		.stat       (stat),
		.cmd        (cmd)
	);

	alfp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.kind     (item.kind),
		.node     (item.node),
		.value    (item.value),
		.capacity (cfg.capacity),
		.out_q    (res)
	);

	// result beat fields
	assign result.status     = res.status;
	assign result.node_index = res.node_index;
	assign result.record     = res.record;
	assign result.next_node  = res.next_node;
	assign result.prev_node  = res.prev_node;
	assign result.head_node  = res.head_node;
	assign result.tail_node  = res.tail_node;
	assign result.count      = res.count;
	assign result.full_res   = res.full_res;

endmodule
